>>> rtl/wsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wsc_pkg;

   // Fixed channel constants
   localparam int PERIOD_SPAN    = 2048;
   localparam int LENGTH_FULL    = 256;
   localparam int STEPS_PER_TICK = 2;
   localparam int SAMPLE_SLOTS   = 32;

   localparam int PERIOD_W  = 11;
   localparam int COUNT_W   = 12;
   localparam int LENGTH_W  = 9;
   localparam int PLAY_W    = $clog2(SAMPLE_SLOTS);
   localparam int ADDR_W    = 4;
   localparam int STORE_D   = 16;
   localparam int BYTE_W    = 8;
   localparam int NIBBLE_W  = 4;
   localparam int OPCODE_W  = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 11;
   localparam int QUEUE_D   = 2;
   localparam int QPTR_W    = $clog2(QUEUE_D);
   localparam int QCNT_W    = $clog2(QUEUE_D + 1);

   localparam logic [NIBBLE_W-1:0] NIBBLE_MASK = 4'hF;

   // Opcodes of the request channel
   localparam logic [OPCODE_W-1:0] OP_TICK         = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_LENGTH_CLOCK = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_TRIGGER      = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_RAM_WRITE    = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_RAM_READ     = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_LENGTH_LOAD  = 3'd5;

   // Register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN_EN  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DAC_EN  = 2'd3;

   // Volume codes
   localparam logic [1:0] VOL_MUTE    = 2'd0;
   localparam logic [1:0] VOL_FULL    = 2'd1;
   localparam logic [1:0] VOL_HALF    = 2'd2;
   localparam logic [1:0] VOL_QUARTER = 2'd3;

   typedef enum logic [2:0] {
      CMD_TICK         = 3'd0,
      CMD_LENGTH_CLOCK = 3'd1,
      CMD_TRIGGER      = 3'd2,
      CMD_WRITE        = 3'd3,
      CMD_READ         = 3'd4,
      CMD_LOAD         = 3'd5,
      CMD_NOP          = 3'd6
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [ADDR_W-1:0]   ram_index;
      logic [LENGTH_W-1:0] data;      // byte for a write, clamped count for a load
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period_value;
      logic [1:0]          volume_code;
      logic                length_enable;
      logic                dac_enable;
   } cfg_type;

   typedef struct packed {
      logic       tick_live;
      logic       tick_dead;
      logic       is_read;
      logic       play_odd;
      logic [1:0] volume_code;
      logic       chan_on;
      logic       dac_on;
   } mid_type;

endpackage
`default_nettype wire

>>> rtl/wsc_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface wsc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [3:0] ram_index;
   logic [8:0] data_value;

   modport source (output valid, output opcode, output ram_index, output data_value,
                   input ready);
   modport sink   (input valid, input opcode, input ram_index, input data_value,
                   output ready);
endinterface
`default_nettype wire

>>> rtl/wsc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface wsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] sample_level;
   logic [7:0] read_data;
   logic       channel_on;

   modport source (output valid, output sample_level, output read_data, output channel_on,
                   input ready);
   modport sink   (input valid, input sample_level, input read_data, input channel_on,
                   output ready);
endinterface
`default_nettype wire

>>> rtl/wsc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module wsc_front
   import wsc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   wsc_req_if.sink     req_chan,
   input  wire logic   q_pop,
   output q_head_type  q_head
);

   cmd_type             queue_ff [QUEUE_D];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             dec_cmd;
   logic                push;
   logic                pop;

   // Classify the opcode and clamp a length load
   always_comb begin
      dec_cmd.ram_index = req_chan.ram_index;
      dec_cmd.data      = req_chan.data_value;
      unique case (req_chan.opcode)
         OP_TICK:         dec_cmd.kind = CMD_TICK;
         OP_LENGTH_CLOCK: dec_cmd.kind = CMD_LENGTH_CLOCK;
         OP_TRIGGER:      dec_cmd.kind = CMD_TRIGGER;
         OP_RAM_WRITE:    dec_cmd.kind = CMD_WRITE;
         OP_RAM_READ:     dec_cmd.kind = CMD_READ;
         OP_LENGTH_LOAD: begin
            dec_cmd.kind = CMD_LOAD;
            if (req_chan.data_value > LENGTH_W'(LENGTH_FULL)) begin
               dec_cmd.data = LENGTH_W'(LENGTH_FULL);
            end
         end
         default:         dec_cmd.kind = CMD_NOP;
      endcase
   end

   assign req_chan.ready = (count_ff != QCNT_W'(QUEUE_D));
   assign push           = req_chan.valid && req_chan.ready;
   assign pop            = q_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_D - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_D - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= dec_cmd;
      end
   end

   assign q_head.valid = (count_ff != '0);
   assign q_head.cmd   = queue_ff[rd_ptr_ff];

endmodule
`default_nettype wire

>>> rtl/wsc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module wsc_back
   import wsc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  q_head_type  q_head,
   input  cfg_type     cfg,
   output logic        q_pop,
   wsc_rsp_if.source   rsp_chan
);

   // Channel state
   logic                channel_en_ff, channel_en_in;
   logic [LENGTH_W-1:0] length_ff, length_in;
   logic [COUNT_W-1:0]  period_cnt_ff, period_cnt_in;
   logic [PLAY_W-1:0]   playhead_ff, playhead_in;
   logic [NIBBLE_W-1:0] out_level_ff;

   // Sample store with per-entry valid bits
   logic [BYTE_W-1:0]   store_mem [STORE_D];
   logic [STORE_D-1:0]  store_vld_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                mem_we;

   // Middle stage
   logic                mid_valid_ff;
   mid_type             mid_ff, mid_in;
   logic [BYTE_W-1:0]   rdata_ff;

   // Result register
   logic                rsp_valid_ff;
   logic [NIBBLE_W-1:0] rsp_level_ff, rsp_level_in;
   logic [BYTE_W-1:0]   rsp_rdata_ff;
   logic                rsp_on_ff;

   logic                advance;
   logic                exec;
   logic                live;
   logic [COUNT_W-1:0]  reload;
   logic [COUNT_W-1:0]  tick_cnt;
   logic [PLAY_W-1:0]   tick_play;
   logic [NIBBLE_W-1:0] nib;
   logic [NIBBLE_W-1:0] shaped;
   logic [NIBBLE_W-1:0] level_new;

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign q_pop   = advance;
   assign exec    = advance && q_head.valid;
   assign live    = channel_en_ff && cfg.dac_enable;
   assign reload  = COUNT_W'(PERIOD_SPAN) - COUNT_W'(cfg.period_value);

   // Step the period timer for one tick
   always_comb begin
      tick_cnt  = period_cnt_ff;
      tick_play = playhead_ff;
      for (int s = 0; s < STEPS_PER_TICK; s++) begin
         tick_cnt = tick_cnt - 1'b1;
         if (tick_cnt == '0) begin
            tick_cnt  = reload;
            tick_play = (tick_play == PLAY_W'(SAMPLE_SLOTS - 1)) ? '0 : tick_play + 1'b1;
         end
      end
   end

   always_comb begin
      channel_en_in = channel_en_ff;
      length_in     = length_ff;
      period_cnt_in = period_cnt_ff;
      playhead_in   = playhead_ff;
      if (exec) begin
         case (q_head.cmd.kind)
            CMD_TICK: begin
               if (live) begin
                  period_cnt_in = tick_cnt;
                  playhead_in   = tick_play;
               end
            end
            CMD_LENGTH_CLOCK: begin
               if (cfg.length_enable && (length_ff != '0)) begin
                  length_in = length_ff - 1'b1;
                  if (length_ff == LENGTH_W'(1)) begin
                     channel_en_in = 1'b0;
                  end
               end
            end
            CMD_TRIGGER: begin
               if (length_ff == '0) begin
                  length_in = LENGTH_W'(LENGTH_FULL);
               end
               period_cnt_in = reload;
               playhead_in   = '0;
               channel_en_in = cfg.dac_enable;
            end
            CMD_LOAD: length_in = q_head.cmd.data;
            default: ;
         endcase
      end
   end

   assign rd_addr = (q_head.cmd.kind == CMD_TICK) ? tick_play[ADDR_W:1]
                                                  : q_head.cmd.ram_index;
   assign mem_we  = exec && (q_head.cmd.kind == CMD_WRITE);

   always_comb begin
      mid_in.tick_live   = (q_head.cmd.kind == CMD_TICK) && live;
      mid_in.tick_dead   = (q_head.cmd.kind == CMD_TICK) && !live;
      mid_in.is_read     = (q_head.cmd.kind == CMD_READ);
      mid_in.play_odd    = tick_play[0];
      mid_in.volume_code = cfg.volume_code;
      mid_in.chan_on     = channel_en_in;
      mid_in.dac_on      = cfg.dac_enable;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[q_head.cmd.ram_index] <= q_head.cmd.data[BYTE_W-1:0];
      end
      if (advance) begin
         rdata_ff <= store_vld_ff[rd_addr] ? store_mem[rd_addr] : '0;
         mid_ff   <= mid_in;
      end
   end

   // Shape the fetched nibble by the volume code
   always_comb begin
      nib = mid_ff.play_odd ? (rdata_ff[NIBBLE_W-1:0] & NIBBLE_MASK)
                            : (rdata_ff[BYTE_W-1:NIBBLE_W] & NIBBLE_MASK);
      unique case (mid_ff.volume_code)
         VOL_FULL:    shaped = nib;
         VOL_HALF:    shaped = nib >> 1;
         VOL_QUARTER: shaped = nib >> 2;
         default:     shaped = '0;
      endcase
      if (mid_ff.tick_live) begin
         level_new = shaped;
      end else if (mid_ff.tick_dead) begin
         level_new = '0;
      end else begin
         level_new = out_level_ff;
      end
      rsp_level_in = (mid_ff.chan_on && mid_ff.dac_on) ? level_new : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_en_ff <= 1'b0;
         length_ff     <= '0;
         period_cnt_ff <= '0;
         playhead_ff   <= '0;
         out_level_ff  <= '0;
         store_vld_ff  <= '0;
         mid_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         channel_en_ff <= channel_en_in;
         length_ff     <= length_in;
         period_cnt_ff <= period_cnt_in;
         playhead_ff   <= playhead_in;
         if (mem_we) begin
            store_vld_ff[q_head.cmd.ram_index] <= 1'b1;
         end
         if (advance) begin
            mid_valid_ff <= q_head.valid;
            rsp_valid_ff <= mid_valid_ff;
            if (mid_valid_ff) begin
               out_level_ff <= level_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && mid_valid_ff) begin
         rsp_level_ff <= rsp_level_in;
         rsp_rdata_ff <= mid_ff.is_read ? rdata_ff : '0;
         rsp_on_ff    <= mid_ff.chan_on;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sample_level = rsp_level_ff;
   assign rsp_chan.read_data    = rsp_rdata_ff;
   assign rsp_chan.channel_on   = rsp_on_ff;

endmodule
`default_nettype wire

>>> rtl/wavetable_sound_channel.sv
// Wavetable sound channel: 32 four-bit samples in a 16-byte store.
// Requests arrive on req_chan as valid/ready transactions carrying an opcode
// (tick, length clock, trigger, store write, store read, length load), a store
// byte index and a data value. Every request yields exactly one rsp_chan
// transaction with the output level, the store byte for a read (zero
// otherwise) and the channel enable after the request took effect.
// The csr port writes period, volume code, length enable and DAC enable; write
// it only while no request is in flight.
// Throughput: one request per cycle while rsp_chan is not stalled. An accepted
// request passes through the queue, the middle stage and the result register;
// the tick's two timer steps and the sample store read feed the middle stage,
// the nibble shaping feeds the result register.
// The front decodes requests into a two-entry queue; req_chan.ready drops only
// when that queue is full. When the receiver stalls rsp_chan, the result and
// the back pipeline hold while the queue keeps taking up to two requests.
// Synchronous reset clears all channel state, the sample store (through
// per-byte valid bits, no clearing pass), the csr registers and the queue.
`timescale 1ns / 1ps
`default_nettype none
module wavetable_sound_channel
   import wsc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   wsc_req_if.sink                   req_chan,
   wsc_rsp_if.source                 rsp_chan,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_write_data
);

   cfg_type    cfg_ff, cfg_in;
   q_head_type q_head;
   logic       q_pop;

   // Decode csr writes; all four indexes name a register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PERIOD: cfg_in.period_value  = csr_write_data[PERIOD_W-1:0];
            CSR_VOLUME: cfg_in.volume_code   = csr_write_data[1:0];
            CSR_LEN_EN: cfg_in.length_enable = csr_write_data[0];
            CSR_DAC_EN: cfg_in.dac_enable    = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept and classify, buffer in the queue
   wsc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_pop    (q_pop),
      .q_head   (q_head)
   );

   // Back: execute against channel state, fetch and shape, drive the result
   wsc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .cfg      (cfg_ff),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

   // A disabled channel reports silence
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.channel_on) |-> (rsp_chan.sample_level == '0))
      else $error("nonzero level while channel is off");

   // Backpressure on requests only comes from a full queue
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> q_head.valid)
      else $error("request stalled with empty queue");

   // No result straight out of reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid right after reset");

   // A queued command with a free result slot is taken
   assert property (@(posedge clock) disable iff (reset)
      (q_head.valid && !rsp_chan.valid) |-> q_pop)
      else $error("queue head not taken with free result slot");

endmodule
`default_nettype wire
